// ===== rtl/sec_pkg.sv =====
// shared types, constants and codes of the stall event coalescer
package sec_pkg;

	localparam int FRAME_BITS   = 32;
	localparam int ID_BITS      = 8;
	localparam int SLOT_BITS    = 2;
	localparam int SERIAL_BITS  = 32;
	localparam int WINDOW_BITS  = 8;
	localparam int QUEUE_DEPTH  = 2;
	localparam int PTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(16);

	typedef enum logic [1:0] {
		OP_STALL   = 2'd0,
		OP_RECOVER = 2'd1,
		OP_HEALTH  = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		KIND_STALL   = 4'b0001,
		KIND_RECOVER = 4'b0010,
		KIND_HEALTH  = 4'b0100,
		KIND_CLEAR   = 4'b1000
	} kind_t;

	typedef struct packed {
		logic [1:0]             operation;
		logic [ID_BITS-1:0]     participant;
		logic [SLOT_BITS-1:0]   player_slot;
		logic [FRAME_BITS-1:0]  frame_number;
		logic [SERIAL_BITS-1:0] health_serial;
	} in_item_t;

	typedef struct packed {
		logic                   newly_tracked;
		logic                   cleared_loggable;
		logic                   resync_request;
		logic                   record_valid;
		logic [ID_BITS-1:0]     record_participant;
		logic [SLOT_BITS-1:0]   record_slot;
		logic [FRAME_BITS-1:0]  record_frame;
		logic [SERIAL_BITS-1:0] record_serial;
		logic                   record_loggable;
		logic                   pending_present;
	} out_item_t;

	// classified request handed from front to back
	typedef struct packed {
		kind_t                  kind;
		logic [ID_BITS-1:0]     participant;
		logic [SLOT_BITS-1:0]   slot;
		logic [FRAME_BITS-1:0]  frame;
		logic [SERIAL_BITS-1:0] serial;
	} cmd_t;

endpackage

// ===== rtl/sec_front.sv =====
// front end: accepts requests, classifies the operation and queues them for the back end
module sec_front import sec_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t event_item,
	output logic     cmd_valid,
	input  logic     cmd_ready,
	output cmd_t     cmd
);

	cmd_t                cmd_in;
	cmd_t                queue_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                wr_en;
	logic                rd_en;

	always_comb begin
		cmd_in.participant = event_item.participant;
		cmd_in.slot        = event_item.player_slot;
		cmd_in.frame       = event_item.frame_number;
		cmd_in.serial      = event_item.health_serial;
		unique case (op_t'(event_item.operation))
			OP_STALL:   cmd_in.kind = KIND_STALL;
			OP_RECOVER: cmd_in.kind = KIND_RECOVER;
			OP_HEALTH:  cmd_in.kind = KIND_HEALTH;
			OP_CLEAR:   cmd_in.kind = KIND_CLEAR;
			default:    cmd_in.kind = KIND_CLEAR;
		endcase
	end

	assign full      = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/sec_back.sv =====
// back end: stall record state, window register and result queue
module sec_back import sec_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  cmd_t                   cmd,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [WINDOW_BITS-1:0] cfg_data,
	output logic                   empty,
	input  logic                   pop,
	output out_item_t              result_item
);

	logic [WINDOW_BITS-1:0] window_q;

	logic                   pend_valid_q,       pend_valid_d;
	logic [ID_BITS-1:0]     pend_participant_q, pend_participant_d;
	logic [SLOT_BITS-1:0]   pend_slot_q,        pend_slot_d;
	logic [FRAME_BITS-1:0]  pend_frame_q,       pend_frame_d;
	logic [SERIAL_BITS-1:0] pend_serial_q,      pend_serial_d;
	logic                   pend_loggable_q,    pend_loggable_d;
	logic                   last_valid_q,       last_valid_d;
	logic [ID_BITS-1:0]     last_participant_q, last_participant_d;
	logic [FRAME_BITS-1:0]  last_frame_q,       last_frame_d;

	logic [FRAME_BITS-1:0]  window_ext;
	logic [FRAME_BITS-1:0]  gap;
	logic [FRAME_BITS-1:0]  since;
	logic                   pend_match;
	logic                   merge;
	logic                   near;
	out_item_t              res;

	out_item_t              res_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]    wr_ptr_q;
	logic [PTR_BITS-1:0]    rd_ptr_q;
	logic [CNT_BITS-1:0]    count_q;
	logic                   fire;
	logic                   rd_en;

	assign cfg_ready   = 1'b1;
	assign cmd_ready   = (count_q != CNT_BITS'(QUEUE_DEPTH));
	assign empty       = (count_q == '0);
	assign result_item = res_q[rd_ptr_q];
	assign fire        = cmd_valid && cmd_ready;
	assign rd_en       = pop && !empty;
	assign window_ext  = FRAME_BITS'(window_q);

	always_comb begin
		pend_match = pend_valid_q && (pend_participant_q == cmd.participant);
		gap   = (cmd.frame > pend_frame_q) ? cmd.frame - pend_frame_q
		                                   : pend_frame_q - cmd.frame;
		merge = pend_match && (gap <= window_ext);
		// distance past the last recovery, zero when not ahead of it
		since = (last_valid_q && (cmd.frame > last_frame_q)) ? cmd.frame - last_frame_q : '0;
		near  = last_valid_q && (last_participant_q == cmd.participant) &&
		        (since != '0) && (since <= window_ext);

		pend_valid_d       = pend_valid_q;
		pend_participant_d = pend_participant_q;
		pend_slot_d        = pend_slot_q;
		pend_frame_d       = pend_frame_q;
		pend_serial_d      = pend_serial_q;
		pend_loggable_d    = pend_loggable_q;
		last_valid_d       = last_valid_q;
		last_participant_d = last_participant_q;
		last_frame_d       = last_frame_q;
		res                = '0;

		unique case (cmd.kind)
			KIND_STALL: begin
				if (merge) begin
					if (cmd.frame < pend_frame_q) begin
						pend_frame_d = cmd.frame;
						pend_slot_d  = cmd.slot;
					end
				end else begin
					pend_valid_d       = 1'b1;
					pend_participant_d = cmd.participant;
					pend_slot_d        = cmd.slot;
					pend_frame_d       = cmd.frame;
					pend_serial_d      = cmd.serial;
					pend_loggable_d    = !near;
					res.newly_tracked  = !near;
				end
				res.record_valid       = 1'b1;
				res.record_participant = pend_participant_d;
				res.record_slot        = pend_slot_d;
				res.record_frame       = pend_frame_d;
				res.record_serial      = pend_serial_d;
				res.record_loggable    = pend_loggable_d;
			end
			KIND_RECOVER: begin
				if (pend_match && (cmd.frame >= pend_frame_q)) begin
					res.cleared_loggable   = pend_loggable_q;
					res.record_valid       = 1'b1;
					res.record_participant = pend_participant_q;
					res.record_slot        = pend_slot_q;
					res.record_frame       = pend_frame_q;
					res.record_serial      = pend_serial_q;
					res.record_loggable    = pend_loggable_q;
					last_valid_d           = 1'b1;
					last_participant_d     = pend_participant_q;
					last_frame_d           = cmd.frame;
					pend_valid_d           = 1'b0;
				end
			end
			KIND_HEALTH: begin
				if (pend_match && (cmd.serial > pend_serial_q)) begin
					if (pend_loggable_q) begin
						res.resync_request     = 1'b1;
						res.record_valid       = 1'b1;
						res.record_participant = pend_participant_q;
						res.record_slot        = pend_slot_q;
						res.record_frame       = pend_frame_q;
						res.record_serial      = pend_serial_q;
						res.record_loggable    = 1'b1;
					end
					pend_valid_d = 1'b0;
				end
			end
			KIND_CLEAR: begin
				pend_valid_d       = 1'b0;
				pend_participant_d = '0;
				pend_slot_d        = '0;
				pend_frame_d       = '0;
				pend_serial_d      = '0;
				pend_loggable_d    = 1'b0;
				last_valid_d       = 1'b0;
				last_participant_d = '0;
				last_frame_d       = '0;
			end
			default: begin
				pend_valid_d = pend_valid_q;
			end
		endcase
		res.pending_present = pend_valid_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q           <= WINDOW_RESET;
			pend_valid_q       <= 1'b0;
			pend_participant_q <= '0;
			pend_slot_q        <= '0;
			pend_frame_q       <= '0;
			pend_serial_q      <= '0;
			pend_loggable_q    <= 1'b0;
			last_valid_q       <= 1'b0;
			last_participant_q <= '0;
			last_frame_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_q <= cfg_data;
			end
			if (fire) begin
				pend_valid_q       <= pend_valid_d;
				pend_participant_q <= pend_participant_d;
				pend_slot_q        <= pend_slot_d;
				pend_frame_q       <= pend_frame_d;
				pend_serial_q      <= pend_serial_d;
				pend_loggable_q    <= pend_loggable_d;
				last_valid_q       <= last_valid_d;
				last_participant_q <= last_participant_d;
				last_frame_q       <= last_frame_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (fire) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (fire && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/stall_event_coalescer.sv =====
// top level of the stall event coalescer: front end, back end and checks
//
// channel   handshake            payload      direction
// input     push / full          event_item   in
// result    pop / empty          result_item  out
// config    cfg_valid/cfg_ready  cfg_data     in (coalesce window, always ready)
//
// one request per cycle sustained while full is low; a taken request waits in the
// front queue, moves into the result queue once the back end takes it and shows on
// the result ports until it is popped
// each side has a two-entry queue, so input keeps flowing while a result waits
// full rises once both queues back up behind an unpopped result
// reset clears both queues and the stall state and sets the window to 16
module stall_event_coalescer import sec_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  in_item_t               event_item,
	output logic                   empty,
	input  logic                   pop,
	output out_item_t              result_item,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [WINDOW_BITS-1:0] cfg_data
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	sec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.event_item (event_item),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd)
	);

	sec_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.empty       (empty),
		.pop         (pop),
		.result_item (result_item)
	);

	// a request stalled between front and back holds until taken
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
		else $error("front to back request changed while stalled");

	a_flags_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> $onehot0({result_item.newly_tracked, result_item.cleared_loggable,
		                     result_item.resync_request}))
		else $error("more than one event flag in a result");

	a_flag_record: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (result_item.newly_tracked || result_item.cleared_loggable ||
		           result_item.resync_request)
		|-> result_item.record_valid && result_item.record_loggable)
		else $error("event flag without a loggable record");

	// retiring a record always leaves nothing pending
	a_retire_clears: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (result_item.cleared_loggable || result_item.resync_request)
		|-> !result_item.pending_present)
		else $error("record retired but still pending");

	a_stall_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result_item.newly_tracked |-> result_item.pending_present)
		else $error("new record without pending state");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the stall event coalescer with an event-level scoreboard

class stall_scoreboard;
	logic [sec_pkg::WINDOW_BITS-1:0] window;
	bit                              pend_valid;
	logic [sec_pkg::ID_BITS-1:0]     pend_participant;
	logic [sec_pkg::SLOT_BITS-1:0]   pend_slot;
	logic [sec_pkg::FRAME_BITS-1:0]  pend_frame;
	logic [sec_pkg::SERIAL_BITS-1:0] pend_serial;
	bit                              pend_loggable;
	bit                              last_valid;
	logic [sec_pkg::ID_BITS-1:0]     last_participant;
	logic [sec_pkg::FRAME_BITS-1:0]  last_frame;
	sec_pkg::out_item_t              expected_results[$];
	int                              errors;

	function new();
		window = sec_pkg::WINDOW_RESET;
		errors = 0;
		clear_tracking();
	endfunction

	function void clear_tracking();
		pend_valid = 0;
		pend_participant = '0;
		pend_slot = '0;
		pend_frame = '0;
		pend_serial = '0;
		pend_loggable = 0;
		last_valid = 0;
		last_participant = '0;
		last_frame = '0;
	endfunction

	task report(string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		errors++;
	endtask

	function sec_pkg::out_item_t with_record(sec_pkg::out_item_t r);
		r.record_valid = 1'b1;
		r.record_participant = pend_participant;
		r.record_slot = pend_slot;
		r.record_frame = pend_frame;
		r.record_serial = pend_serial;
		r.record_loggable = pend_loggable;
		return r;
	endfunction

	function sec_pkg::out_item_t stall_outcome(sec_pkg::in_item_t ev);
		sec_pkg::out_item_t              res;
		logic [sec_pkg::FRAME_BITS-1:0] gap;
		logic [sec_pkg::FRAME_BITS-1:0] since;
		bit                              merged;
		bit                              near;
		res = '0;
		case (sec_pkg::op_t'(ev.operation))
			sec_pkg::OP_STALL: begin
				merged = 0;
				if (pend_valid && pend_participant == ev.participant) begin
					gap = (ev.frame_number > pend_frame) ? ev.frame_number - pend_frame
						: pend_frame - ev.frame_number;
					if (gap <= window) begin
						// merge keeps the earliest frame and the slot seen with it
						if (ev.frame_number < pend_frame) begin
							pend_frame = ev.frame_number;
							pend_slot = ev.player_slot;
						end
						merged = 1;
					end
				end
				if (!merged) begin
					since = (last_valid && ev.frame_number > last_frame)
						? ev.frame_number - last_frame : '0;
					near = last_valid && last_participant == ev.participant
						&& since != 0 && since <= window;
					pend_valid = 1;
					pend_participant = ev.participant;
					pend_slot = ev.player_slot;
					pend_frame = ev.frame_number;
					pend_serial = ev.health_serial;
					pend_loggable = !near;
					res.newly_tracked = !near;
				end
				res = with_record(res);
			end
			sec_pkg::OP_RECOVER: begin
				if (pend_valid && pend_participant == ev.participant
					&& ev.frame_number >= pend_frame) begin
					res.cleared_loggable = pend_loggable;
					res = with_record(res);
					last_valid = 1;
					last_participant = pend_participant;
					last_frame = ev.frame_number;
					pend_valid = 0;
				end
			end
			sec_pkg::OP_HEALTH: begin
				if (pend_valid && pend_participant == ev.participant
					&& ev.health_serial > pend_serial) begin
					if (pend_loggable) begin
						res.resync_request = 1'b1;
						res = with_record(res);
					end
					pend_valid = 0;
				end
			end
			default: begin
				clear_tracking();
			end
		endcase
		res.pending_present = pend_valid;
		return res;
	endfunction

	function void note_event(sec_pkg::in_item_t ev);
		expected_results.push_back(stall_outcome(ev));
	endfunction

	task check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	task check_result(sec_pkg::out_item_t got);
		sec_pkg::out_item_t want;
		if (expected_results.size() == 0) begin
			report("result popped with no event waiting for one");
			return;
		end
		want = expected_results.pop_front();
		check_field("newly_tracked", 64'(got.newly_tracked), 64'(want.newly_tracked));
		check_field("cleared_loggable", 64'(got.cleared_loggable),
			64'(want.cleared_loggable));
		check_field("resync_request", 64'(got.resync_request), 64'(want.resync_request));
		check_field("record_valid", 64'(got.record_valid), 64'(want.record_valid));
		check_field("record_participant", 64'(got.record_participant),
			64'(want.record_participant));
		check_field("record_slot", 64'(got.record_slot), 64'(want.record_slot));
		check_field("record_frame", 64'(got.record_frame), 64'(want.record_frame));
		check_field("record_serial", 64'(got.record_serial), 64'(want.record_serial));
		check_field("record_loggable", 64'(got.record_loggable),
			64'(want.record_loggable));
		check_field("pending_present", 64'(got.pending_present),
			64'(want.pending_present));
	endtask
endclass

module tb;
	import sec_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   push;
	logic                   full;
	in_item_t               event_item;
	logic                   empty;
	logic                   pop;
	out_item_t              result_item;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [WINDOW_BITS-1:0] cfg_data;

	stall_scoreboard sb;
	int              hold_left = 0;
	bit              quiet = 0;

	stall_event_coalescer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.event_item  (event_item),
		.empty       (empty),
		.pop         (pop),
		.result_item (result_item),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.window = cfg_data;
			if (push && !full)
				sb.note_event(event_item);
			if (pop && !empty)
				sb.check_result(result_item);
		end
	end

	// mostly back to back, some short pauses, rare long ones
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_item_t ev_of(op_t op, int unsigned who, int unsigned slot,
		logic [FRAME_BITS-1:0] frame, logic [SERIAL_BITS-1:0] serial);
		in_item_t ev;
		ev.operation = op;
		ev.participant = ID_BITS'(who);
		ev.player_slot = SLOT_BITS'(slot);
		ev.frame_number = frame;
		ev.health_serial = serial;
		return ev;
	endfunction

	// events aimed at the tracked record so merges, recoveries and drops happen often
	function automatic in_item_t make_event();
		in_item_t              ev;
		int unsigned           r;
		int unsigned           span;
		int                    off;
		logic [FRAME_BITS-1:0] base;
		logic [ID_BITS-1:0]    pool [3];
		pool[0] = '0;
		pool[1] = ID_BITS'(1);
		pool[2] = '1;
		if ($urandom_range(0, 99) < 8) begin
			ev.operation = 2'($urandom);
			ev.participant = ID_BITS'($urandom);
			ev.player_slot = SLOT_BITS'($urandom);
			ev.frame_number = FRAME_BITS'($urandom);
			ev.health_serial = SERIAL_BITS'($urandom);
			return ev;
		end
		r = $urandom_range(0, 99);
		ev.operation = (r < 42) ? OP_STALL : (r < 70) ? OP_RECOVER : (r < 97) ? OP_HEALTH
			: OP_CLEAR;
		r = $urandom_range(0, 99);
		if (r < 65 && sb.pend_valid)
			ev.participant = sb.pend_participant;
		else if (r < 65 && sb.last_valid)
			ev.participant = sb.last_participant;
		else if (r < 88)
			ev.participant = pool[2'($urandom_range(0, 2))];
		else
			ev.participant = ID_BITS'($urandom);
		ev.player_slot = SLOT_BITS'($urandom_range(0, 3));
		if (sb.pend_valid)
			base = sb.pend_frame;
		else if (sb.last_valid)
			base = sb.last_frame;
		else if ($urandom_range(0, 3) == 0)
			base = '1 - FRAME_BITS'(8);
		else
			base = FRAME_BITS'($urandom);
		span = sb.window + 3;
		off = int'($urandom_range(0, 2 * span)) - int'(span);
		ev.frame_number = ($urandom_range(0, 9) == 0) ? FRAME_BITS'($urandom)
			: base + FRAME_BITS'(off);
		if ($urandom_range(0, 9) < 7)
			ev.health_serial = sb.pend_serial + SERIAL_BITS'($urandom_range(0, 3))
				- SERIAL_BITS'(1);
		else
			ev.health_serial = SERIAL_BITS'($urandom);
		return ev;
	endfunction

	// called and returns at a falling edge; push stays high for a following request
	task automatic send_event(in_item_t ev);
		push <= 1'b1;
		event_item <= ev;
		do
			@(posedge clk);
		while (full);
		@(negedge clk);
	endtask

	task automatic idle_sender(int n);
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_window(logic [WINDOW_BITS-1:0] w);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= w;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : result_sink
		int idle_left;
		int run_left;
		idle_left = 0;
		run_left = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (idle_left > 0) begin
				pop <= 1'b0;
				idle_left--;
			end else begin
				pop <= 1'b1;
				if (run_left > 0) begin
					run_left--;
				end else begin
					idle_left = quiet ? 0 : pick_gap();
					run_left = $urandom_range(0, 15);
				end
			end
		end
	end

	initial begin : stimulus
		logic [WINDOW_BITS-1:0] w;
		sb = new();
		arst_n = 1'b0;
		push = 1'b0;
		event_item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// window at its reset value of 16
		send_event(ev_of(OP_STALL, 0, 1, 100, 5));
		send_event(ev_of(OP_STALL, 0, 2, 90, 6));          // earlier frame merges
		send_event(ev_of(OP_STALL, 0, 3, 106, 7));         // distance equal to window
		send_event(ev_of(OP_STALL, 1, 0, 95, 8));          // other participant replaces
		send_event(ev_of(OP_STALL, 1, 0, 112, 9));         // one past the window
		send_event(ev_of(OP_RECOVER, 0, 0, 200, 0));       // wrong participant
		send_event(ev_of(OP_RECOVER, 1, 0, 111, 0));       // below stalled frame
		send_event(ev_of(OP_RECOVER, 1, 0, 112, 0));       // exactly at stalled frame
		send_event(ev_of(OP_RECOVER, 1, 0, 300, 0));       // nothing pending
		send_event(ev_of(OP_STALL, 1, 2, 128, 50));        // closely follows recovery
		send_event(ev_of(OP_HEALTH, 1, 0, 0, 50));         // serial not newer
		send_event(ev_of(OP_HEALTH, 2, 0, 0, 99));         // wrong participant
		send_event(ev_of(OP_HEALTH, 1, 0, 0, 51));         // silent drop
		send_event(ev_of(OP_STALL, 1, 1, 112, 60));        // same frame as recovery
		send_event(ev_of(OP_HEALTH, 1, 0, 0, 61));         // resync
		send_event(ev_of(OP_STALL, 1, 3, 129, 0));
		send_event(ev_of(OP_RECOVER, 1, 0, 200, 0));
		send_event(ev_of(OP_STALL, 1, 0, 201, 0));
		send_event(ev_of(OP_RECOVER, 1, 0, 201, 0));       // retires a quiet record
		send_event(ev_of(OP_STALL, 255, 3, '1, '1));
		send_event(ev_of(OP_STALL, 255, 0, '0, '0));       // no wrap in the distance
		send_event(ev_of(OP_CLEAR, 0, 0, 0, 0));
		send_event(ev_of(OP_RECOVER, 255, 0, '1, 0));
		send_event(ev_of(OP_STALL, 0, 0, 0, 0));

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: w = '1;
				1: w = '0;
				2: w = WINDOW_BITS'(1);
				4: w = WINDOW_RESET;
				default: w = WINDOW_BITS'($urandom_range(2, 254));
			endcase
			write_window(w);
			quiet = (ph == 2);
			for (int i = 0; i < 280; i++) begin
				if (ph == 0 && i == 40)
					hold_left = 300;
				if (ph == 0 && i == 200)
					wait_drained();
				send_event(make_event());
				if (!quiet)
					idle_sender(pick_gap());
			end
		end

		wait_drained();
		repeat (8) @(negedge clk);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("watchdog expired with %0d results outstanding", sb.expected_results.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
